### src/lsgd_pkg.sv
`default_nettype none

package lsgd_pkg;

  localparam int unsigned MAX_FEATURES = 8;
  localparam int unsigned FEAT_W       = 16;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned PROD_W       = 48;
  localparam int unsigned ERR_W        = 40;
  localparam int unsigned LR_W         = 16;
  localparam int unsigned INV_W        = 24;
  localparam int unsigned TOL_W        = 16;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned IN_DATA_W    = 144;
  localparam int unsigned OUT_DATA_W   = 80;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 32'sd6554;
  localparam logic [LR_W-1:0]            LR_RESET     = 16'd655;
  localparam logic [INV_W-1:0]           INV_RESET    = 24'hFFFFFF;
  localparam logic [TOL_W-1:0]           TOL_RESET    = 16'd1;

  localparam logic [CFG_ADDR_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERSE_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE     = 2'd2;

  localparam logic OP_TRAIN = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_ERR,
    S_SCALE,
    S_DELTA,
    S_STEP
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic delta_en;
    logic upd_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic mul_en;
    logic scale_en;
    logic commit;
    logic last;
  } err_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [39:0] r;
    if (v > 64'sh0000_007F_FFFF_FFFF) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < -64'sh0000_0080_0000_0000) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/linear_regression_sgd.sv
// channel   dir  tdata (low bit up)                               tlast      tuser
// s_axis    in   feature_0..feature_7, target_value (144 bits)   pass_end   op
// m_axis    out  prediction, pass_error, converged, pad (80)     pass_done  -
// cfg       in   cfg_we_i, cfg_addr_i, cfg_data_i, no read-back
//
// each sample runs accept, lane multiply, merge tree, error multiply, error scale,
// lane delta multiply, lane weight step (train only); the weights of a sample
// feed the next one, so samples run one at a time
// the result sits in an output register; a stalled m_axis holds the last stage
// reset sets weights to 0.1 and config defaults, clears pass sums and output valid at once, no sweep
`default_nettype none

module linear_regression_sgd #(
  parameter int unsigned FEATURES = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [143:0]  s_axis_tdata,  // feature_0..feature_7, target_value
  input  wire logic          s_axis_tlast,
  input  wire logic [0:0]    s_axis_tuser,  // op
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [79:0]        m_axis_tdata,  // prediction, pass_error, converged, zeros
  output logic               m_axis_tlast,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_addr_i,
  input  wire logic [23:0]   cfg_data_i
);

  lsgd_pkg::state_e state_q, state_d;
  lsgd_pkg::lane_ctrl_t lane_ctrl;
  lsgd_pkg::err_ctrl_t  err_ctrl;
  logic sum_en;
  logic load_out;
  logic accept;

  logic [15:0] lr_q;
  logic [23:0] inv_q;
  logic [15:0] tol_q;

  logic signed [15:0] feat_q [lsgd_pkg::MAX_FEATURES];
  logic signed [15:0] target_q;
  logic               op_q;
  logic               last_q;

  logic signed [47:0] prod [FEATURES];
  logic signed [31:0] pred;
  logic signed [39:0] err;
  logic signed [39:0] sum_nxt;
  logic               conv;

  logic               m_valid_q;
  logic signed [31:0] pred_out_q;
  logic signed [39:0] perr_out_q;
  logic               conv_out_q;
  logic               last_out_q;

  assign s_axis_tready = (state_q == lsgd_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= lsgd_pkg::LR_RESET;
      inv_q <= lsgd_pkg::INV_RESET;
      tol_q <= lsgd_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lsgd_pkg::REG_LEARNING_RATE: lr_q  <= cfg_data_i[15:0];
        lsgd_pkg::REG_INVERSE_COUNT: inv_q <= cfg_data_i;
        lsgd_pkg::REG_TOLERANCE:     tol_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < lsgd_pkg::MAX_FEATURES; k++) begin
        feat_q[k] <= s_axis_tdata[16*k +: 16];
      end
      target_q <= s_axis_tdata[143:128];
      op_q     <= s_axis_tuser[0];
      last_q   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsgd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    lane_ctrl      = '0;
    err_ctrl       = '0;
    err_ctrl.last  = last_q;
    sum_en         = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      lsgd_pkg::S_IDLE: begin
        if (accept) begin
          state_d = lsgd_pkg::S_MUL;
        end
      end
      lsgd_pkg::S_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        state_d          = lsgd_pkg::S_SUM;
      end
      lsgd_pkg::S_SUM: begin
        sum_en  = 1'b1;
        state_d = lsgd_pkg::S_ERR;
      end
      lsgd_pkg::S_ERR: begin
        err_ctrl.mul_en = 1'b1;
        state_d         = lsgd_pkg::S_SCALE;
      end
      lsgd_pkg::S_SCALE: begin
        err_ctrl.scale_en = 1'b1;
        state_d           = lsgd_pkg::S_DELTA;
      end
      lsgd_pkg::S_DELTA: begin
        lane_ctrl.delta_en = 1'b1;
        state_d            = lsgd_pkg::S_STEP;
      end
      lsgd_pkg::S_STEP: begin
        if (!m_valid_q || m_axis_tready) begin
          lane_ctrl.upd_en = (op_q == lsgd_pkg::OP_TRAIN);
          err_ctrl.commit  = 1'b1;
          load_out         = 1'b1;
          state_d          = lsgd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lsgd_pkg::S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < FEATURES; g++) begin : g_lane
    lsgd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .feature_i (feat_q[g]),
      .err_i     (err),
      .lr_i      (lr_q),
      .prod_o    (prod[g])
    );
  end

  lsgd_merge #(
    .FEATURES (FEATURES)
  ) u_merge (
    .clk_i    (clk_i),
    .sum_en_i (sum_en),
    .prod_i   (prod),
    .pred_o   (pred)
  );

  lsgd_err u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (err_ctrl),
    .pred_i   (pred),
    .target_i (target_q),
    .inv_i    (inv_q),
    .tol_i    (tol_q),
    .err_o    (err),
    .sum_o    (sum_nxt),
    .conv_o   (conv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pred_out_q <= pred;
      perr_out_q <= last_q ? sum_nxt : '0;
      conv_out_q <= last_q && conv;
      last_out_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, conv_out_q, perr_out_q, pred_out_q};
  assign m_axis_tlast  = last_out_q;

endmodule

`default_nettype wire

### src/lsgd_lane.sv
`default_nettype none

module lsgd_lane (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lsgd_pkg::lane_ctrl_t    ctrl_i,
  input  wire logic signed [15:0]      feature_i,
  input  wire logic signed [39:0]      err_i,
  input  wire logic        [15:0]      lr_i,
  output logic signed      [47:0]      prod_o
);

  logic signed [31:0] weight_q, weight_d;
  logic signed [47:0] prod_q;
  logic signed [39:0] delta_q;
  logic signed [55:0] err_prod;
  logic signed [16:0] lr_s;
  logic signed [56:0] step_prod;
  logic signed [40:0] step;
  logic signed [41:0] w_new;

  assign err_prod  = 56'(err_i) * 56'(feature_i);
  assign lr_s      = {1'b0, lr_i};
  assign step_prod = 57'(delta_q) * 57'(lr_s);
  assign step      = step_prod[56:16];
  assign w_new     = 42'(weight_q) - 42'(step);
  assign weight_d  = lsgd_pkg::sat32(64'(w_new));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= lsgd_pkg::WEIGHT_RESET;
    end else if (ctrl_i.upd_en) begin
      weight_q <= weight_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= 48'(weight_q) * 48'(feature_i);
    end
    if (ctrl_i.delta_en) begin
      delta_q <= err_prod[55:16];
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### src/lsgd_merge.sv
`default_nettype none

module lsgd_merge #(
  parameter int unsigned FEATURES = 8
) (
  input  wire logic               clk_i,
  input  wire logic               sum_en_i,
  input  wire logic signed [47:0] prod_i [FEATURES],
  output logic signed      [31:0] pred_o
);

  logic signed [50:0] acc;
  logic signed [31:0] pred_q;

  always_comb begin
    acc = '0;
    for (int k = 0; k < FEATURES; k++) begin
      acc = acc + 51'(prod_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      pred_q <= lsgd_pkg::sat32(64'(acc >>> 8));
    end
  end

  assign pred_o = pred_q;

endmodule

`default_nettype wire

### src/lsgd_err.sv
`default_nettype none

module lsgd_err (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lsgd_pkg::err_ctrl_t   ctrl_i,
  input  wire logic signed [31:0]    pred_i,
  input  wire logic signed [15:0]    target_i,
  input  wire logic        [23:0]    inv_i,
  input  wire logic        [15:0]    tol_i,
  output logic signed      [39:0]    err_o,
  output logic signed      [39:0]    sum_o,
  output logic                       conv_o
);

  logic signed [33:0] diff;
  logic signed [24:0] inv_s;
  logic signed [58:0] prod_q;
  logic signed [39:0] err_q;
  logic signed [39:0] err_sum_q, prev_q;
  logic signed [39:0] sum_nxt;
  logic signed [40:0] change;
  logic        [40:0] mag;

  assign diff  = 34'(pred_i) - (34'(target_i) <<< 8);
  assign inv_s = {1'b0, inv_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= 59'(diff) * 59'(inv_s);
    end
    if (ctrl_i.scale_en) begin
      err_q <= lsgd_pkg::sat40(64'(prod_q >>> 16));
    end
  end

  assign sum_nxt = lsgd_pkg::sat40(64'(err_sum_q) + 64'(err_q));
  assign change  = 41'(sum_nxt) - 41'(prev_q);
  assign mag     = change[40] ? 41'(-change) : 41'(change);
  assign conv_o  = (mag <= {17'b0, tol_i, 8'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q <= '0;
      prev_q    <= '0;
    end else if (ctrl_i.commit) begin
      if (ctrl_i.last) begin
        prev_q    <= sum_nxt;
        err_sum_q <= '0;
      end else begin
        err_sum_q <= sum_nxt;
      end
    end
  end

  assign err_o = err_q;
  assign sum_o = sum_nxt;

endmodule

`default_nettype wire

### src/lsgd_checker.sv
`default_nettype none

module lsgd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a sample in flight");

  // pass sum and flag only at pass end
  a_pass_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[79:32] == 48'd0))
    else $error("pass fields set mid-pass");

  // ready returns once the result is loaded
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not reopened with result");

endmodule

bind linear_regression_sgd lsgd_checker u_lsgd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
